/* rtl/assert_macros.svh */
// assertion macros for the rtl modules, used by the queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define GTWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define GTWS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

`endif

/* rtl/gtws_pkg.sv */
// package: types, constants, tables and sine helper for the gfsk synthesizer
`default_nettype none
package gtws_pkg;

  localparam int unsigned Symbols          = 79;
  localparam int unsigned SamplesPerSymbol = 1920;
  localparam int unsigned FrameLen         = Symbols * SamplesPerSymbol;
  localparam int unsigned RampLen          = SamplesPerSymbol / 8;
  localparam int unsigned FifoDepth        = 4;
  localparam logic [31:0] ToneStepReset    = 32'd357913941;
  localparam logic [13:0] Amplitude        = 14'd12000;

  localparam logic KindLoad   = 1'b0;
  localparam logic KindSample = 1'b1;

  // one queued word
  typedef struct packed {
    logic        kind;
    logic [6:0]  tone_index;
    logic [2:0]  tone_value;
    logic [17:0] sample_index;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_QUO, ST_REM, ST_TADDR, ST_TK, ST_TM, ST_TP, ST_TQ, ST_TE,
    ST_INC, ST_SIN, ST_GA, ST_GB, ST_GC, ST_MUL1, ST_MUL2
  } st_e;

  // gaussian pulse edge, every 1/16 symbol
  function automatic logic [15:0] edge_val(input logic [3:0] k);
    logic [15:0] v;
    case (k)
      4'd0:    v = 16'd16384;
      4'd1:    v = 16'd10439;
      4'd2:    v = 16'd5661;
      4'd3:    v = 16'd2573;
      4'd4:    v = 16'd970;
      4'd5:    v = 16'd301;
      4'd6:    v = 16'd76;
      4'd7:    v = 16'd16;
      4'd8:    v = 16'd3;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // quarter-wave sine, q15, 33 points
  function automatic logic [15:0] qsine(input logic [5:0] i);
    logic [15:0] v;
    case (i)
      6'd0:  v = 16'd0;     6'd1:  v = 16'd1608;  6'd2:  v = 16'd3212;
      6'd3:  v = 16'd4808;  6'd4:  v = 16'd6393;  6'd5:  v = 16'd7962;
      6'd6:  v = 16'd9512;  6'd7:  v = 16'd11039; 6'd8:  v = 16'd12540;
      6'd9:  v = 16'd14010; 6'd10: v = 16'd15447; 6'd11: v = 16'd16846;
      6'd12: v = 16'd18205; 6'd13: v = 16'd19520; 6'd14: v = 16'd20788;
      6'd15: v = 16'd22006; 6'd16: v = 16'd23170; 6'd17: v = 16'd24280;
      6'd18: v = 16'd25330; 6'd19: v = 16'd26320; 6'd20: v = 16'd27246;
      6'd21: v = 16'd28106; 6'd22: v = 16'd28899; 6'd23: v = 16'd29622;
      6'd24: v = 16'd30274; 6'd25: v = 16'd30853; 6'd26: v = 16'd31358;
      6'd27: v = 16'd31787; 6'd28: v = 16'd32138; 6'd29: v = 16'd32413;
      6'd30: v = 16'd32610; 6'd31: v = 16'd32729;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

  // q15 sine of a 16-bit angle, interpolated
  function automatic logic signed [16:0] sine16(input logic [15:0] a);
    logic [14:0] pos;
    logic [5:0]  idx;
    logic [8:0]  fr;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [19:0] prod;
    logic [16:0] v;
    pos = a[14] ? 15'(15'd16384 - {1'b0, a[13:0]}) : {1'b0, a[13:0]};
    idx = pos[14:9];
    fr  = pos[8:0];
    lo  = qsine(idx);
    hi  = qsine(6'(idx + 6'd1));
    prod = 20'(hi - lo) * 20'(fr);
    if (idx >= 6'd32) begin
      v = 17'd32768;
    end else begin
      v = 17'(lo) + 17'(prod >> 9);
    end
    return a[15] ? -$signed(v) : $signed(v);
  endfunction

endpackage
`default_nettype wire

/* rtl/gtws_fifo.sv */
// short word queue between the front and the back
`default_nettype none
`include "assert_macros.svh"
module gtws_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire gtws_pkg::item_t push_item_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output gtws_pkg::item_t      pop_item_o
);

  gtws_pkg::item_t mem_q [gtws_pkg::FifoDepth];
  logic [1:0] wr_ptr_q, wr_ptr_d;
  logic [1:0] rd_ptr_q, rd_ptr_d;
  logic [2:0] count_q, count_d;

  assign full_o     = (count_q == 3'(gtws_pkg::FifoDepth));
  assign valid_o    = (count_q != 3'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = push_i ? 2'(wr_ptr_q + 2'd1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? 2'(rd_ptr_q + 2'd1) : rd_ptr_q;
    count_d  = 3'(count_q + 3'(push_i) - 3'(pop_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `GTWS_ASSERT(a_count_bound, count_q <= 3'(gtws_pkg::FifoDepth), "queue count overflow")
  `GTWS_ASSERT_IMP(a_no_pop_empty, pop_i, count_q != 3'd0, "pop from empty queue")
  `GTWS_ASSERT_IMP(a_no_push_full, push_i, !full_o, "push into full queue")

endmodule
`default_nettype wire

/* rtl/gtws_front.sv */
// front: accepts input words, drops out-of-range loads, feeds the queue
`default_nettype none
module gtws_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [6:0]  tone_index_i,
  input  wire logic [2:0]  tone_value_i,
  input  wire logic [17:0] sample_index_i,
  input  wire logic        full_i,
  output logic             push_o,
  output gtws_pkg::item_t  push_item_o
);

  logic            valid_q;
  gtws_pkg::item_t item_q;
  logic            accept;
  logic            keep;

  assign push_o      = valid_q && !full_i;
  assign push_item_o = item_q;
  assign in_ready_o  = !valid_q || !full_i;
  assign accept      = in_valid_i && in_ready_o;

  // loads beyond the frame are dropped here
  assign keep = (kind_i == gtws_pkg::KindSample) ||
                (tone_index_i < 7'(gtws_pkg::Symbols));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= keep;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.kind         <= kind_i;
      item_q.tone_index   <= tone_index_i;
      item_q.tone_value   <= tone_value_i;
      item_q.sample_index <= sample_index_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/gtws_back.sv */
// back: tone store, pulse-sum sequencer, phase, sine, ramp and output register
`default_nettype none
module gtws_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            tone_step_we_i,
  input  wire logic [31:0]     tone_step_i,
  input  wire logic            valid_i,
  input  wire gtws_pkg::item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic signed [14:0]   audio_sample_o
);

  gtws_pkg::st_e state_q, state_d;
  logic [2:0]  j_q;
  logic [31:0] tone_step_q;
  logic [31:0] phase_q;
  logic        out_valid_q;
  logic signed [14:0] audio_q;

  logic [2:0]  tone_mem [gtws_pkg::Symbols];
  logic [2:0]  rd_q;

  logic [17:0] si_q;
  logic [7:0]  q_q;
  logic [10:0] rem_q;
  logic [11:0] w_q;
  logic        inner_q;
  logic [5:0]  k_q;
  logic [6:0]  m_q;
  logic [15:0] tabk_q;
  logic [12:0] diff_q;
  logic [19:0] prod_q;
  logic [13:0] qv_q;
  logic [20:0] acc_q;
  logic [19:0] r_q;
  logic signed [16:0] sn_q;
  logic [7:0]  ridx_q;
  logic [15:0] ang_q;
  logic [15:0] smag_q;
  logic [15:0] gain_q;
  logic [16:0] svmag_q;
  logic        svneg_q;

  logic [18:0] shaped;
  logic        t_valid;
  logic [6:0]  t_sym;
  logic [13:0] t_p;
  logic [13:0] twice_p;
  logic [12:0] d_c;
  logic        last_term;
  logic        out_free;
  logic        is_load;

  assign shaped    = 19'(19'(si_q) + 19'(gtws_pkg::SamplesPerSymbol));
  assign last_term = (j_q == 3'd4);
  assign out_free  = !out_valid_q || out_ready_i;
  assign is_load   = (item_i.kind == gtws_pkg::KindLoad);
  assign out_valid_o    = out_valid_q;
  assign audio_sample_o = audio_q;

  // selection of the current pulse term
  always_comb begin
    t_valid = 1'b0;
    t_sym   = '0;
    t_p     = '0;
    case (j_q)
      3'd0, 3'd1, 3'd2: begin
        t_valid = (q_q >= 8'(j_q)) && (8'(q_q - 8'(j_q)) < 8'(gtws_pkg::Symbols));
        t_sym   = 7'(q_q - 8'(j_q));
        t_p     = 14'(14'(rem_q) + 14'(j_q) * 14'(gtws_pkg::SamplesPerSymbol));
      end
      3'd3: begin
        t_valid = shaped < 19'(2 * gtws_pkg::SamplesPerSymbol);
        t_sym   = 7'd0;
        t_p     = 14'(shaped + 19'(gtws_pkg::SamplesPerSymbol));
      end
      3'd4: begin
        // the pulse is zero past its three-symbol span
        t_valid = (shaped >= 19'(gtws_pkg::FrameLen)) &&
                  (shaped < 19'(gtws_pkg::FrameLen + 3 * gtws_pkg::SamplesPerSymbol));
        t_sym   = 7'(gtws_pkg::Symbols - 1);
        t_p     = 14'(shaped - 19'(gtws_pkg::FrameLen));
      end
      default: begin
        t_valid = 1'b0;
      end
    endcase
    twice_p = 14'(t_p << 1);
    d_c = (twice_p >= 14'(3 * gtws_pkg::SamplesPerSymbol))
        ? 13'(twice_p - 14'(3 * gtws_pkg::SamplesPerSymbol))
        : 13'(14'(3 * gtws_pkg::SamplesPerSymbol) - twice_p);
  end

  // next state
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    case (state_q)
      gtws_pkg::ST_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          if (!is_load) begin
            state_d = gtws_pkg::ST_QUO;
          end
        end
      end
      gtws_pkg::ST_QUO:   state_d = gtws_pkg::ST_REM;
      gtws_pkg::ST_REM:   state_d = gtws_pkg::ST_TADDR;
      gtws_pkg::ST_TADDR: begin
        if (t_valid) begin
          state_d = gtws_pkg::ST_TK;
        end else if (last_term) begin
          state_d = gtws_pkg::ST_INC;
        end
      end
      gtws_pkg::ST_TK:    state_d = gtws_pkg::ST_TM;
      gtws_pkg::ST_TM:    state_d = gtws_pkg::ST_TP;
      gtws_pkg::ST_TP:    state_d = gtws_pkg::ST_TQ;
      gtws_pkg::ST_TQ:    state_d = gtws_pkg::ST_TE;
      gtws_pkg::ST_TE:    state_d = last_term ? gtws_pkg::ST_INC : gtws_pkg::ST_TADDR;
      gtws_pkg::ST_INC:   state_d = gtws_pkg::ST_SIN;
      gtws_pkg::ST_SIN: begin
        if (si_q < 18'(gtws_pkg::RampLen) ||
            (si_q >= 18'(gtws_pkg::FrameLen - gtws_pkg::RampLen) &&
             si_q < 18'(gtws_pkg::FrameLen))) begin
          state_d = gtws_pkg::ST_GA;
        end else begin
          state_d = gtws_pkg::ST_MUL1;
        end
      end
      gtws_pkg::ST_GA:    state_d = gtws_pkg::ST_GB;
      gtws_pkg::ST_GB:    state_d = gtws_pkg::ST_GC;
      gtws_pkg::ST_GC:    state_d = gtws_pkg::ST_MUL1;
      gtws_pkg::ST_MUL1:  state_d = gtws_pkg::ST_MUL2;
      gtws_pkg::ST_MUL2: begin
        if (out_free) begin
          state_d = gtws_pkg::ST_IDLE;
        end
      end
      default: state_d = gtws_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gtws_pkg::ST_IDLE;
      j_q         <= '0;
      tone_step_q <= gtws_pkg::ToneStepReset;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (tone_step_we_i) begin
        tone_step_q <= tone_step_i;
      end
      if (state_q == gtws_pkg::ST_QUO) begin
        j_q <= '0;
        if (si_q == 18'd0) begin
          phase_q <= '0;
        end
      end
      if ((state_q == gtws_pkg::ST_TADDR && !t_valid && !last_term) ||
          (state_q == gtws_pkg::ST_TE && !last_term)) begin
        j_q <= 3'(j_q + 3'd1);
      end
      // phase advance: base step plus pulse sum scaled by 2^10/15
      if (state_q == gtws_pkg::ST_SIN) begin
        phase_q <= 32'(phase_q + tone_step_q + 32'(acc_q) * 32'd68 + 32'(r_q));
      end
      if (state_q == gtws_pkg::ST_MUL2 && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // tone store
  always_ff @(posedge clk_i) begin
    if (state_q == gtws_pkg::ST_IDLE && valid_i && is_load) begin
      tone_mem[item_i.tone_index] <= item_i.tone_value;
    end
    if (state_q == gtws_pkg::ST_TADDR) begin
      rd_q <= tone_mem[t_sym];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      gtws_pkg::ST_IDLE: begin
        si_q  <= item_i.sample_index;
        acc_q <= '0;
      end
      gtws_pkg::ST_QUO: begin
        q_q <= 8'((24'(shaped[18:7]) * 24'd4370) >> 16);
      end
      gtws_pkg::ST_REM: begin
        rem_q <= 11'(shaped - 19'(q_q) * 19'(gtws_pkg::SamplesPerSymbol));
      end
      gtws_pkg::ST_TADDR: begin
        inner_q <= d_c < 13'(gtws_pkg::SamplesPerSymbol);
        w_q <= (d_c < 13'(gtws_pkg::SamplesPerSymbol))
             ? 12'(13'(gtws_pkg::SamplesPerSymbol) - d_c)
             : 12'(d_c - 13'(gtws_pkg::SamplesPerSymbol));
      end
      gtws_pkg::ST_TK: begin
        k_q <= 6'((22'(w_q[11:3]) * 22'd4370) >> 16);
      end
      gtws_pkg::ST_TM: begin
        m_q <= 7'(w_q - 12'(k_q) * 12'd120);
        if (k_q < 6'd9) begin
          tabk_q <= gtws_pkg::edge_val(k_q[3:0]);
          diff_q <= 13'(gtws_pkg::edge_val(k_q[3:0]) -
                        gtws_pkg::edge_val(4'(k_q[3:0] + 4'd1)));
        end else begin
          tabk_q <= '0;
          diff_q <= '0;
        end
      end
      gtws_pkg::ST_TP: begin
        prod_q <= 20'(diff_q) * 20'(m_q);
      end
      gtws_pkg::ST_TQ: begin
        qv_q <= 14'((34'(prod_q[19:3]) * 34'd69906) >> 20);
      end
      gtws_pkg::ST_TE: begin
        acc_q <= 21'(acc_q + 21'(rd_q) * (inner_q
                 ? 21'(21'd32768 - 21'(tabk_q - 16'(qv_q)))
                 : 21'(tabk_q - 16'(qv_q))));
      end
      gtws_pkg::ST_INC: begin
        r_q <= 20'((48'({acc_q, 2'b00}) * 48'd17895698) >> 28);
      end
      gtws_pkg::ST_SIN: begin
        sn_q <= gtws_pkg::sine16(phase_q[31:16]);
        ridx_q <= (si_q < 18'(gtws_pkg::RampLen))
                ? 8'(si_q)
                : 8'(18'(gtws_pkg::FrameLen - 1) - si_q);
        gain_q <= (si_q >= 18'(gtws_pkg::FrameLen)) ? 16'd0 : 16'd32768;
      end
      gtws_pkg::ST_GA: begin
        // ramp angle i*16384/(samples per symbol / 8) = i*68 + i*4/15
        ang_q <= 16'(16'(ridx_q) * 16'd68 +
                 16'((24'({ridx_q, 2'b00}) * 24'd4370) >> 16));
      end
      gtws_pkg::ST_GB: begin
        smag_q <= 16'(gtws_pkg::sine16(ang_q));
      end
      gtws_pkg::ST_GC: begin
        gain_q <= 16'((32'(smag_q) * 32'(smag_q)) >> 15);
      end
      gtws_pkg::ST_MUL1: begin
        svneg_q <= sn_q[16];
        svmag_q <= 17'((32'(sn_q[16] ? 17'(-sn_q) : 17'(sn_q)) * 32'(gain_q)) >> 15);
      end
      gtws_pkg::ST_MUL2: begin
        if (out_free) begin
          audio_q <= svneg_q
                   ? -$signed(15'((31'(svmag_q) * 31'(gtws_pkg::Amplitude)) >> 15))
                   :  $signed(15'((31'(svmag_q) * 31'(gtws_pkg::Amplitude)) >> 15));
        end
      end
      default: begin
        si_q <= si_q;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/gfsk_tone_waveform_synth_core.sv */
// gfsk tone synthesizer top level: front, word queue and back
// a load word passes the front register and the queue and is written to the tone store; a
// sample word also passes the back states QUO, REM, per pulse term TADDR and, if active, TK,
// TM, TP, TQ, TE, then INC, SIN, GA, GB, GC in the ramps, and MUL1 and MUL2, which waits
// for a free output; the back walks each sample's pulse terms through one datapath in turn
// reset clears control, the phase and the queue and loads tone_step; the store is not cleared
`default_nettype none
module gfsk_tone_waveform_synth_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        tone_step_we_i,
  input  wire logic [31:0] tone_step_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [6:0]  tone_index_i,
  input  wire logic [2:0]  tone_value_i,
  input  wire logic [17:0] sample_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic signed [14:0] audio_sample_o
);

  logic            push;
  logic            full;
  logic            pop;
  logic            q_valid;
  gtws_pkg::item_t push_item;
  gtws_pkg::item_t pop_item;

  // front
  gtws_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .tone_index_i   (tone_index_i),
    .tone_value_i   (tone_value_i),
    .sample_index_i (sample_index_i),
    .full_i         (full),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  // queue
  gtws_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // back
  gtws_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tone_step_we_i (tone_step_we_i),
    .tone_step_i    (tone_step_i),
    .valid_i        (q_valid),
    .item_i         (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .audio_sample_o (audio_sample_o)
  );

endmodule
`default_nettype wire
